// ===== rtl/selt_pkg.sv =====
// ----------------------------------------------------------------------------
// selt_pkg
// Shared types, codes and defaults for the shared/exclusive lock table.
// ----------------------------------------------------------------------------
package selt_pkg;

  localparam int RESOURCES_DEF = 16;
  localparam int SLOTS_DEF     = 4;
  localparam int TXN_W         = 8;
  localparam int RES_W         = 4;
  localparam int CNT_W         = 5;
  localparam int IN_W          = 16;
  localparam int OUT_W         = 24;

  typedef enum logic [1:0] {
    OP_ACQUIRE,
    OP_UPGRADE,
    OP_RELEASE,
    OP_RELEASE_ALL
  } op_t;

  typedef enum logic [2:0] {
    ST_GRANTED,
    ST_HELD,
    ST_QUEUED,
    ST_DENIED,
    ST_RELEASED,
    ST_NOT_HELD,
    ST_WAITER,
    ST_FULL
  } status_t;

  // one request slot (valid bit lives in flops beside the memory)
  typedef struct packed {
    logic             gr;
    logic [TXN_W-1:0] own;
    logic             ex;
  } slot_t;

  // result beat, first field in the high bits
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             ex;
    logic [RES_W-1:0] res;
    logic [TXN_W-1:0] txn;
    status_t          st;
  } item_t;

  typedef struct packed {
    logic load_in;
    logic load_row;
    logic do_op;
    logic do_grant;
    logic do_strip;
    logic wb;
    logic res_inc;
    logic do_sum;
    logic pick_next;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic rall;
    logic oor;
    logic rel_ok;
    logic grant_hit;
    logic ra_end;
    logic touched_any;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/selt_dp.sv =====
// ----------------------------------------------------------------------------
// selt_dp
// Datapath: slot memory, working row, op/grant/strip logic, result staging.
// ----------------------------------------------------------------------------
module selt_dp #(
  parameter int RESOURCES = selt_pkg::RESOURCES_DEF,
  parameter int SLOTS     = selt_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [selt_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [selt_pkg::OUT_W-1:0] m_tdata,
  output logic                       m_tlast,
  input  selt_pkg::cmd_t             cmd,
  output selt_pkg::sts_t             sts
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int TW = selt_pkg::TXN_W;
  localparam int QW = selt_pkg::RES_W;

  typedef selt_pkg::slot_t [SLOTS-1:0] row_t;
  typedef logic [SLOTS-1:0]            vrow_t;

  // shift later slots down over slot j
  function automatic row_t drop_s(row_t s, logic [SW-1:0] j);
    row_t r;
    r = s;
    for (int k = 0; k < SLOTS - 1; k++) begin
      if (SW'(k) >= j) r[k] = s[k+1];
    end
    return r;
  endfunction

  function automatic vrow_t drop_v(vrow_t v, logic [SW-1:0] j);
    vrow_t r;
    r = v;
    for (int k = 0; k < SLOTS; k++) begin
      if (SW'(k) >= j) r[k] = (k < SLOTS - 1) ? v[k+1] : 1'b0;
    end
    return r;
  endfunction

  // latched input beat
  selt_pkg::op_t  in_op;
  logic [TW-1:0]  in_txn;
  logic [QW-1:0]  in_res;
  logic           in_want;
  logic           in_wait;

  logic [QW-1:0]  cur_res;
  logic [RW-1:0]  idx;
  row_t           mem [RESOURCES];
  vrow_t          vld [RESOURCES];
  row_t           rd_q;
  row_t           row_s;
  vrow_t          row_v;
  logic [RESOURCES-1:0]        touched;
  logic [selt_pkg::CNT_W-1:0]  cnt;
  selt_pkg::item_t pend;
  logic            pend_v;
  selt_pkg::item_t out_item;
  logic            push;
  logic            push_last;

  assign idx = cur_res[RW-1:0];

  // ---- row analysis for the requesting transaction ----
  logic          g_hit, p_hit, s_hit, blk_sh, blk_ex, g_ex, full;
  logic [SW-1:0] g_idx, s_idx, app_idx;
  logic [CW-1:0] n;

  always_comb begin
    g_hit = 1'b0; g_idx = '0; p_hit = 1'b0; s_hit = 1'b0; s_idx = '0;
    blk_sh = 1'b0; blk_ex = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (row_v[i] && row_s[i].own == in_txn) begin
        if (row_s[i].gr) begin
          g_hit = 1'b1; g_idx = SW'(i);
          if (!row_s[i].ex) begin
            s_hit = 1'b1; s_idx = SW'(i);
          end
        end else begin
          p_hit = 1'b1;
        end
      end
      if (row_v[i] && row_s[i].gr) begin
        if (row_s[i].ex) blk_sh = 1'b1;
        if (row_s[i].own != in_txn) blk_ex = 1'b1;
      end
    end
    n       = CW'($countones(row_v));
    full    = (n == CW'(SLOTS));
    app_idx = n[SW-1:0];
    g_ex    = row_s[g_idx].ex;
  end

  logic oor;
  assign oor = ({1'b0, in_res} >= (QW + 1)'(RESOURCES));

  // ---- acquire / upgrade / release on the working row ----
  selt_pkg::status_t o_st;
  logic              o_ex, o_rel;
  row_t              o_s;
  vrow_t             o_v;

  always_comb begin
    logic do_upg, fit;
    do_upg = (in_op == selt_pkg::OP_UPGRADE) ||
             (in_op == selt_pkg::OP_ACQUIRE && g_hit && !g_ex && in_want);
    fit    = in_want ? !blk_ex : !blk_sh;
    o_s = row_s; o_v = row_v; o_st = selt_pkg::ST_DENIED; o_ex = 1'b0; o_rel = 1'b0;
    if (oor) begin
      o_st = (in_op == selt_pkg::OP_RELEASE) ? selt_pkg::ST_NOT_HELD : selt_pkg::ST_DENIED;
      o_ex = (in_op == selt_pkg::OP_RELEASE) ? 1'b0 :
             (in_op == selt_pkg::OP_UPGRADE) ? 1'b1 : in_want;
    end else if (do_upg) begin
      o_ex = 1'b1;
      if (!s_hit) o_st = selt_pkg::ST_DENIED;
      else if (!blk_ex) begin
        o_s[s_idx].ex = 1'b1;
        o_st = selt_pkg::ST_GRANTED;
      end else if (!in_wait) o_st = selt_pkg::ST_DENIED;
      else if (p_hit) o_st = selt_pkg::ST_QUEUED;
      else if (full) o_st = selt_pkg::ST_FULL;
      else begin
        o_v[app_idx] = 1'b1;
        o_s[app_idx] = '{gr: 1'b0, own: in_txn, ex: 1'b1};
        o_st = selt_pkg::ST_QUEUED;
      end
    end else if (in_op == selt_pkg::OP_ACQUIRE) begin
      o_ex = in_want;
      if (g_hit) begin
        o_st = selt_pkg::ST_HELD;
        o_ex = g_ex;
      end else if (fit) begin
        if (full) o_st = selt_pkg::ST_FULL;
        else begin
          o_v[app_idx] = 1'b1;
          o_s[app_idx] = '{gr: 1'b1, own: in_txn, ex: in_want};
          o_st = selt_pkg::ST_GRANTED;
        end
      end else if (!in_wait) o_st = selt_pkg::ST_DENIED;
      else if (p_hit) o_st = selt_pkg::ST_QUEUED;
      else if (full) o_st = selt_pkg::ST_FULL;
      else begin
        o_v[app_idx] = 1'b1;
        o_s[app_idx] = '{gr: 1'b0, own: in_txn, ex: in_want};
        o_st = selt_pkg::ST_QUEUED;
      end
    end else begin
      if (!g_hit) o_st = selt_pkg::ST_NOT_HELD;
      else begin
        o_ex  = g_ex;
        o_st  = selt_pkg::ST_RELEASED;
        o_rel = 1'b1;
        o_s   = drop_s(row_s, g_idx);
        o_v   = drop_v(row_v, g_idx);
      end
    end
  end

  // ---- one waiter grant ----
  logic          gr_hit;
  logic [SW-1:0] gi;
  row_t          w_s;
  vrow_t         w_v;
  logic [TW-1:0] w_txn;
  logic          w_ex;

  always_comb begin
    logic [SLOTS-1:0] c1, c2, fx, hg;
    logic             h1, dj_hit;
    logic [SW-1:0]    i1, i2, dj;
    for (int i = 0; i < SLOTS; i++) begin
      fx[i] = 1'b1; hg[i] = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
        if (row_v[j] && row_s[j].gr) begin
          if (row_s[j].own != row_s[i].own) fx[i] = 1'b0;
          else hg[i] = 1'b1;
        end
      end
      c1[i] = row_v[i] && !row_s[i].gr && row_s[i].ex && hg[i] && fx[i];
      c2[i] = row_v[i] && !row_s[i].gr && (row_s[i].ex ? fx[i] : !blk_sh);
    end
    h1 = |c1; i1 = '0; i2 = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (c1[i]) i1 = SW'(i);
      if (c2[i]) i2 = SW'(i);
    end
    gr_hit = h1 || (|c2);
    gi     = h1 ? i1 : i2;
    w_txn  = row_s[gi].own;
    w_ex   = row_s[gi].ex;
    w_s    = row_s;
    w_s[gi].gr = 1'b1;
    w_v    = row_v;
    dj_hit = 1'b0; dj = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (SW'(j) != gi && row_v[j] && row_s[j].gr && row_s[j].own == w_txn) begin
        dj_hit = 1'b1; dj = SW'(j);
      end
    end
    if (w_ex && dj_hit) begin
      w_s = drop_s(w_s, dj);
      w_v = drop_v(row_v, dj);
    end
  end

  // ---- strip every slot of the transaction (release all) ----
  row_t        x_s;
  vrow_t       x_v;
  logic [CW-1:0] x_cnt;
  logic        x_rm;

  always_comb begin
    logic [CW-1:0] pos;
    pos = '0; x_s = row_s; x_v = '0; x_cnt = '0; x_rm = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (row_v[i]) begin
        if (row_s[i].own != in_txn) begin
          x_v[pos[SW-1:0]] = 1'b1;
          x_s[pos[SW-1:0]] = row_s[i];
          pos = pos + CW'(1);
        end else begin
          x_rm = 1'b1;
          if (row_s[i].gr) x_cnt = x_cnt + CW'(1);
        end
      end
    end
  end

  logic [QW-1:0] nxt;
  always_comb begin
    nxt = '0;
    for (int i = RESOURCES - 1; i >= 0; i--) begin
      if (touched[i]) nxt = QW'(i);
    end
  end

  // ---- memory: one row port, registered read ----
  always_ff @(posedge clk) begin
    rd_q <= mem[idx];
    if (cmd.wb) mem[idx] <= row_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < RESOURCES; r++) vld[r] <= '0;
    end else if (cmd.wb) begin
      vld[idx] <= row_v;
    end
  end

  // ---- working registers ----
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_op   <= selt_pkg::op_t'(s_tdata[1:0]);
      in_txn  <= s_tdata[9:2];
      in_res  <= s_tdata[13:10];
      in_want <= s_tdata[14];
      in_wait <= s_tdata[15];
      cur_res <= (selt_pkg::op_t'(s_tdata[1:0]) == selt_pkg::OP_RELEASE_ALL) ?
                 '0 : s_tdata[13:10];
      cnt     <= '0;
      touched <= '0;
    end
    if (cmd.load_row) begin
      row_s <= rd_q;
      row_v <= vld[idx];
    end
    if (cmd.do_op) begin
      row_s <= o_s;
      row_v <= o_v;
      pend  <= '{cnt: '0, ex: o_ex, res: in_res, txn: in_txn, st: o_st};
    end
    if (cmd.do_grant) begin
      row_s <= w_s;
      row_v <= w_v;
      pend  <= '{cnt: '0, ex: w_ex, res: cur_res, txn: w_txn, st: selt_pkg::ST_WAITER};
    end
    if (cmd.do_strip) begin
      row_s <= x_s;
      row_v <= x_v;
      cnt   <= cnt + selt_pkg::CNT_W'(x_cnt);
      if (x_rm) touched[idx] <= 1'b1;
    end
    if (cmd.res_inc) cur_res <= cur_res + QW'(1);
    if (cmd.do_sum) begin
      pend <= '{cnt: cnt, ex: 1'b0, res: '0, txn: in_txn,
                st: (|touched) ? selt_pkg::ST_RELEASED : selt_pkg::ST_NOT_HELD};
    end
    if (cmd.pick_next) begin
      cur_res             <= nxt;
      touched[nxt[RW-1:0]] <= 1'b0;
    end
  end

  // ---- staging: a beat goes out once the next one (or the end) is known ----
  assign push      = cmd.flush || (cmd.do_grant && pend_v);
  assign push_last = cmd.flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.do_op || cmd.do_sum || cmd.do_grant) pend_v <= 1'b1;
      else if (cmd.flush) pend_v <= 1'b0;
      if (push) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_item <= pend;
      m_tlast  <= push_last;
    end
  end

  assign m_tdata = {3'b000, out_item};

  assign sts.rall        = (in_op == selt_pkg::OP_RELEASE_ALL);
  assign sts.oor         = oor;
  assign sts.rel_ok      = o_rel;
  assign sts.grant_hit   = gr_hit;
  assign sts.ra_end      = (cur_res == QW'(RESOURCES - 1));
  assign sts.touched_any = |touched;
  assign sts.out_free    = !m_tvalid || m_tready;

endmodule

// ===== rtl/selt_ctrl.sv =====
// ----------------------------------------------------------------------------
// selt_ctrl
// Controller: sequences row read, op or strip, waiter grants, write-back, summary and flush.
// ----------------------------------------------------------------------------
module selt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output selt_pkg::cmd_t cmd,
  input  selt_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RD, S_LOAD, S_OP, S_GRANT, S_WB,
    S_STRIP, S_RA_WB, S_SUM, S_NEXT, S_FLUSH
  } state_t;

  state_t state;
  logic   ra_grant;  // release all: second pass, granting waiters

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load_in   = (state == S_IDLE) && s_tvalid;
    cmd.load_row  = (state == S_LOAD);
    cmd.do_op     = (state == S_OP);
    cmd.do_grant  = (state == S_GRANT) && sts.grant_hit && sts.out_free;
    cmd.do_strip  = (state == S_STRIP);
    cmd.wb        = (state == S_WB) || (state == S_RA_WB);
    cmd.res_inc   = (state == S_RA_WB) && !sts.ra_end;
    cmd.do_sum    = (state == S_SUM);
    cmd.pick_next = (state == S_NEXT) && sts.touched_any;
    cmd.flush     = (state == S_FLUSH) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ra_grant <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_DECODE;
        end
        S_DECODE: begin
          ra_grant <= 1'b0;
          if (sts.rall) state <= S_RD;
          else if (sts.oor) state <= S_OP;
          else state <= S_RD;
        end
        S_RD: state <= S_LOAD;
        S_LOAD: begin
          if (sts.rall && !ra_grant) state <= S_STRIP;
          else if (sts.rall) state <= S_GRANT;
          else state <= S_OP;
        end
        S_OP: begin
          if (sts.oor) state <= S_FLUSH;
          else if (sts.rel_ok) state <= S_GRANT;
          else state <= S_WB;
        end
        S_GRANT: begin
          if (!sts.grant_hit) state <= S_WB;
        end
        S_WB: state <= sts.rall ? S_NEXT : S_FLUSH;
        S_STRIP: state <= S_RA_WB;
        S_RA_WB: state <= sts.ra_end ? S_SUM : S_RD;
        S_SUM: begin
          ra_grant <= 1'b1;
          state    <= S_NEXT;
        end
        S_NEXT: state <= sts.touched_any ? S_RD : S_FLUSH;
        S_FLUSH: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/shared_exclusive_lock_table.sv =====
// ----------------------------------------------------------------------------
// shared_exclusive_lock_table
// Two-phase-locking lock table with shared and exclusive request slots.
// ----------------------------------------------------------------------------
// One request beat at a time. Acquire, upgrade and release on a resource run
// from accept to the last result beat through idle, decode, row read, row
// load, op, write-back and flush. A release adds a search for waiters, which
// grants one waiter at a time and waits while the output is stalled. Release
// all sweeps every resource (read, load, strip, write-back), then writes a
// summary, then for each resource it touched runs next, read, load, grant
// search and write-back, and ends with a final scan and flush. The sequence
// is set by the slot memory's single row port: each resource's slot list is
// one row, read into a working register, changed there and written back. Slot
// contents come up undefined after reset; per-slot valid flops are cleared at
// once, so there is no clearing pass. Result beats leave through an output
// register; a staging register holds each beat until it is known whether
// another one follows, so m_tlast marks the final beat of every request. A
// new request is accepted only after its predecessor's last beat has been
// handed to the output.
// ----------------------------------------------------------------------------
module shared_exclusive_lock_table #(
  parameter int RESOURCES          = selt_pkg::RESOURCES_DEF,
  parameter int SLOTS_PER_RESOURCE = selt_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // opcode[1:0], txn_id[9:2], resource_id[13:10], want_exclusive[14],
  // may_wait[15]
  input  logic [selt_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // status[2:0], out_txn[10:3], out_resource[14:11], out_exclusive[15],
  // released_count[20:16], zero[23:21]
  output logic [selt_pkg::OUT_W-1:0] m_tdata,
  output logic                       m_tlast
);

  selt_pkg::cmd_t cmd;
  selt_pkg::sts_t sts;

  selt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  selt_dp #(
    .RESOURCES (RESOURCES),
    .SLOTS     (SLOTS_PER_RESOURCE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ===== rtl/selt_chk.sv =====
// ----------------------------------------------------------------------------
// selt_chk
// Port-level checks for the lock table, bound to the top level.
// ----------------------------------------------------------------------------
module selt_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [selt_pkg::IN_W-1:0]  s_tdata,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [selt_pkg::OUT_W-1:0] m_tdata,
  input logic                       m_tlast
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

  // only the release-all summary carries a count
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[20:16] != 5'd0 |->
      m_tdata[2:0] == selt_pkg::ST_RELEASED && m_tdata[14:11] == 4'd0)
    else $error("released count on a non-summary beat");

  // single-answer statuses always end the request
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == selt_pkg::ST_GRANTED ||
                 m_tdata[2:0] == selt_pkg::ST_HELD ||
                 m_tdata[2:0] == selt_pkg::ST_QUEUED ||
                 m_tdata[2:0] == selt_pkg::ST_DENIED ||
                 m_tdata[2:0] == selt_pkg::ST_FULL) |-> m_tlast)
    else $error("single-answer beat not marked last");

endmodule

bind shared_exclusive_lock_table selt_chk u_chk (.*);
